// ===== src/locc_pkg.sv =====
// Shared types and constants for the lock order cycle checker.
package locc_pkg;

  localparam int ID_W   = 4;   // lock_id, edge_from, edge_to
  localparam int STAT_W = 3;
  localparam int MAX_OUT = 16; // cap on results for one deadlock report
  localparam int K_W    = 5;

  typedef enum logic {
    FN_ACQUIRE = 1'b0,
    FN_RELEASE = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_DEADLOCK     = 3'd1,
    ST_POP_EMPTY    = 3'd2,
    ST_POP_MISMATCH = 3'd3,
    ST_FULL         = 3'd4,
    ST_HALTED       = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_EROW,
    S_PUSH,
    S_ROOT,
    S_LOADROW,
    S_SCAN,
    S_POP,
    S_REP0,
    S_PRD,
    S_PWAIT,
    S_PEMIT,
    S_EMIT
  } state_t;

endpackage

// ===== src/locc_if.sv =====
// Request and response channel interfaces.
interface locc_req_if import locc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            func;
  logic [ID_W-1:0] lock_id;

  modport source (output valid, func, lock_id, input ready);
  modport sink   (input valid, func, lock_id, output ready);
endinterface

interface locc_rsp_if import locc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   edge_from;
  logic [ID_W-1:0]   edge_to;
  logic              last;

  modport source (output valid, status, edge_from, edge_to, last, input ready);
  modport sink   (input valid, status, edge_from, edge_to, last, output ready);
endinterface

// ===== src/locc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module locc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lock_order_cycle_checker_core.sv =====
// Lock order checker: held-lock stack, lock-order edge matrix, DFS cycle search.
// A release, or an acquire of a repeated lock or a known edge, gives its result without a search.
// An acquire that adds a new edge runs a DFS over the edge RAM, one edge check per cycle while scanning a row.
// It reports up to MAX_OUT cycle edges, one result at a time, waiting while the output register is not free.
// One item at a time; the next item is taken once the last result is in the output register.
// Synchronous reset clears the edge row valid bits, known mask, held count and halt flag.
module lock_order_cycle_checker_core import locc_pkg::*; #(
  parameter int NUM_LOCKS   = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  locc_req_if.sink    req,
  locc_rsp_if.source  rsp
);

  localparam int LW = $clog2(NUM_LOCKS);
  localparam int CW = $clog2(NUM_LOCKS + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int HW = $clog2(STACK_DEPTH + 1);
  localparam int FW = LW + CW + NUM_LOCKS;

  state_t state, state_next;

  logic                 func_q;
  logic [ID_W-1:0]      id_q;
  logic                 halted;
  logic [NUM_LOCKS-1:0] known;
  logic [NUM_LOCKS-1:0] visited;
  logic [NUM_LOCKS-1:0] done_m;
  logic [NUM_LOCKS-1:0] row_valid;
  logic [HW-1:0]        held_count;
  logic [LW-1:0]        prev_q;
  logic [NUM_LOCKS-1:0] row_q;
  logic [LW-1:0]        here_q;
  logic [CW-1:0]        c_q;
  logic [CW-1:0]        sp_q;
  logic [CW-1:0]        root_q;
  logic [LW-1:0]        there_q;
  logic [LW-1:0]        now_q;
  logic [LW-1:0]        p_q;
  logic [K_W-1:0]       k_q;
  status_t              st_q;

  // RAM ports
  logic                 hs_we;
  logic [SW-1:0]        hs_waddr, hs_raddr;
  logic [LW-1:0]        hs_rdata;
  logic                 er_we;
  logic [LW-1:0]        er_raddr, er_raddr_q;
  logic [NUM_LOCKS-1:0] er_wdata, er_rdata;
  logic                 wk_we;
  logic [LW-1:0]        wk_waddr, wk_raddr;
  logic [FW-1:0]        wk_wdata, wk_rdata;
  logic [LW-1:0]        par_rdata;

  logic                 accept, in_range, slot_free, rsp_load;
  logic [LW-1:0]        idl, c_idx, root_idx;
  logic [NUM_LOCKS-1:0] edge_row;
  logic                 c_end, root_end, row_bit, root_new, rep0_last, pemit_last;

  assign accept    = req.valid && req.ready;
  assign in_range  = {{(32-ID_W){1'b0}}, req.lock_id} < 32'(NUM_LOCKS);
  assign slot_free = !rsp.valid || rsp.ready;
  assign rsp_load  = slot_free && (state == S_REP0 || state == S_PEMIT || state == S_EMIT);
  assign idl       = LW'(id_q);
  assign c_idx     = c_q[LW-1:0];
  assign root_idx  = root_q[LW-1:0];
  assign c_end     = (c_q == CW'(NUM_LOCKS));
  assign root_end  = (root_q == CW'(NUM_LOCKS));
  assign row_bit   = row_q[c_idx];
  assign root_new  = known[root_idx] && !visited[root_idx];
  assign edge_row  = row_valid[er_raddr_q] ? er_rdata : '0;
  assign rep0_last = (here_q == there_q);
  assign pemit_last = (k_q == K_W'(MAX_OUT - 1)) || (p_q == there_q);

  locc_ram #(.WIDTH(LW), .DEPTH(STACK_DEPTH)) u_held (
    .clk, .we(hs_we), .waddr(hs_waddr), .wdata(idl), .raddr(hs_raddr), .rdata(hs_rdata)
  );
  locc_ram #(.WIDTH(NUM_LOCKS), .DEPTH(NUM_LOCKS)) u_edges (
    .clk, .we(er_we), .waddr(prev_q), .wdata(er_wdata), .raddr(er_raddr), .rdata(er_rdata)
  );
  locc_ram #(.WIDTH(FW), .DEPTH(NUM_LOCKS)) u_walk (
    .clk, .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata), .raddr(wk_raddr), .rdata(wk_rdata)
  );
  locc_ram #(.WIDTH(LW), .DEPTH(NUM_LOCKS)) u_parent (
    .clk, .we(wk_we), .waddr(c_idx), .wdata(here_q), .raddr(now_q), .rdata(par_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (halted || !in_range) begin
            state_next = S_EMIT;
          end else if (req.func == FN_ACQUIRE) begin
            state_next = (held_count != '0) ? S_TOP : S_PUSH;
          end else begin
            state_next = (held_count != '0) ? S_TOP : S_EMIT;
          end
        end
      end
      S_TOP: begin
        if (func_q == FN_RELEASE) begin
          state_next = S_EMIT;
        end else begin
          state_next = (hs_rdata == idl) ? S_PUSH : S_EROW;
        end
      end
      S_EROW:    state_next = edge_row[idl] ? S_PUSH : S_ROOT;
      S_PUSH:    state_next = S_EMIT;
      S_ROOT: begin
        if (root_end) begin
          state_next = S_PUSH;
        end else if (root_new) begin
          state_next = S_LOADROW;
        end
      end
      S_LOADROW: state_next = S_SCAN;
      S_SCAN: begin
        if (c_end) begin
          state_next = (sp_q == '0) ? S_ROOT : S_POP;
        end else if (row_bit && !visited[c_idx]) begin
          state_next = S_LOADROW;
        end else if (row_bit && !done_m[c_idx]) begin
          state_next = S_REP0;
        end
      end
      S_POP:     state_next = S_SCAN;
      S_REP0: begin
        if (slot_free) begin
          state_next = rep0_last ? S_IDLE : S_PRD;
        end
      end
      S_PRD:     state_next = S_PWAIT;
      S_PWAIT:   state_next = S_PEMIT;
      S_PEMIT: begin
        if (slot_free) begin
          state_next = pemit_last ? S_IDLE : S_PRD;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // handshake and RAM controls
  always_comb begin
    req.ready = (state == S_IDLE);
    hs_raddr  = SW'(held_count - HW'(1));
    hs_we     = (state == S_PUSH) && (held_count != HW'(STACK_DEPTH));
    hs_waddr  = held_count[SW-1:0];
    er_we     = (state == S_EROW) && !edge_row[idl];
    er_wdata  = edge_row | (NUM_LOCKS'(1) << idl);
    unique case (state)
      S_TOP:   er_raddr = hs_rdata;
      S_ROOT:  er_raddr = root_idx;
      S_SCAN:  er_raddr = c_idx;
      default: er_raddr = prev_q;
    endcase
    wk_we    = (state == S_SCAN) && !c_end && row_bit && !visited[c_idx];
    wk_waddr = sp_q[LW-1:0];
    wk_wdata = {here_q, c_q + CW'(1), row_q};
    wk_raddr = LW'(sp_q - CW'(1));
  end

  always_ff @(posedge clk) begin
    er_raddr_q <= er_raddr;
    if (rst) begin
      state      <= S_IDLE;
      halted     <= 1'b0;
      known      <= '0;
      visited    <= '0;
      done_m     <= '0;
      row_valid  <= '0;
      held_count <= '0;
      sp_q       <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_q <= req.func;
            id_q   <= req.lock_id;
            if (halted) begin
              st_q <= ST_HALTED;
            end else if (!in_range) begin
              st_q <= ST_OK;
            end else if (req.func == FN_ACQUIRE) begin
              known[LW'(req.lock_id)] <= 1'b1;
            end else if (held_count == '0) begin
              st_q   <= ST_POP_EMPTY;
              halted <= 1'b1;
            end
          end
        end
        S_TOP: begin
          prev_q <= hs_rdata;
          if (func_q == FN_RELEASE) begin
            if (hs_rdata != idl) begin
              st_q   <= ST_POP_MISMATCH;
              halted <= 1'b1;
            end else begin
              held_count <= held_count - HW'(1);
              st_q       <= ST_OK;
            end
          end
        end
        S_EROW: begin
          if (!edge_row[idl]) begin
            row_valid[prev_q] <= 1'b1;
            visited <= '0;
            done_m  <= '0;
            root_q  <= '0;
          end
        end
        S_PUSH: begin
          if (held_count == HW'(STACK_DEPTH)) begin
            st_q   <= ST_FULL;
            halted <= 1'b1;
          end else begin
            held_count <= held_count + HW'(1);
            st_q       <= ST_OK;
          end
        end
        S_ROOT: begin
          if (!root_end) begin
            root_q <= root_q + CW'(1);
            if (root_new) begin
              visited[root_idx] <= 1'b1;
              here_q <= root_idx;
              c_q    <= '0;
              sp_q   <= '0;
            end
          end
        end
        S_LOADROW: row_q <= edge_row;
        S_SCAN: begin
          if (c_end) begin
            done_m[here_q] <= 1'b1;
            if (sp_q != '0) begin
              sp_q <= sp_q - CW'(1);
            end
          end else if (row_bit && !visited[c_idx]) begin
            // descend: parent frame saved to walk RAM
            sp_q <= sp_q + CW'(1);
            visited[c_idx] <= 1'b1;
            here_q <= c_idx;
            c_q    <= '0;
          end else if (row_bit && !done_m[c_idx]) begin
            there_q <= c_idx;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end
        S_POP: {here_q, c_q, row_q} <= wk_rdata;
        S_REP0: begin
          if (slot_free) begin
            rsp.status    <= ST_DEADLOCK;
            rsp.edge_from <= ID_W'(here_q);
            rsp.edge_to   <= ID_W'(there_q);
            rsp.last      <= rep0_last;
            now_q <= here_q;
            k_q   <= K_W'(1);
            if (rep0_last) begin
              halted <= 1'b1;
            end
          end
        end
        S_PRD: ;
        S_PWAIT: p_q <= par_rdata;
        S_PEMIT: begin
          if (slot_free) begin
            rsp.status    <= ST_DEADLOCK;
            rsp.edge_from <= ID_W'(p_q);
            rsp.edge_to   <= ID_W'(now_q);
            rsp.last      <= pemit_last;
            now_q <= p_q;
            k_q   <= k_q + K_W'(1);
            if (pemit_last) begin
              halted <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp.status    <= st_q;
            rsp.edge_from <= '0;
            rsp.edge_to   <= '0;
            rsp.last      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= HW'(STACK_DEPTH))
    else $error("held count beyond stack depth");

  a_walk_depth: assert property (@(posedge clk) disable iff (rst)
    sp_q < CW'(NUM_LOCKS) || state == S_IDLE)
    else $error("walk stack overflow");

  a_scan_visited: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> visited[here_q])
    else $error("scanning an unvisited node");

  a_halt_reply: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req.valid && halted) |=> (state == S_EMIT && st_q == ST_HALTED))
    else $error("halted block did not answer halted");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_DEADLOCK) |-> rsp.last)
    else $error("non-deadlock result without last");

endmodule
